// ===== src/xcc_pkg.sv =====
// Shared constants and types of the XOR chaining cipher with key table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package xcc_pkg;

    // Key table geometry
    localparam int KEY_TABLE_DEPTH = 512;
    localparam int KT_AW           = $clog2(KEY_TABLE_DEPTH);
    // Key index also holds the depth itself (the wrap point)
    localparam int KI_W            = $clog2(KEY_TABLE_DEPTH + 1);

    // Park-Miller minimal standard generator
    localparam logic [14:0] GEN_MULT    = 15'd16807;
    localparam logic [31:0] GEN_MODULUS = 32'h7FFF_FFFF;

    // Register widths and reset values
    localparam int SEED_W = 31;
    localparam int RANGE_W = 15;
    localparam logic [SEED_W-1:0]  SEED_RST  = 31'd666666;
    localparam logic [RANGE_W-1:0] RANGE_RST = 15'd256;

    // Key table write port (fill side)
    typedef struct packed {
        logic             en;
        logic [KT_AW-1:0] addr;
        logic [7:0]       data;
    } t_key_wr;

    // Key table read request: two consecutive entries per beat
    typedef struct packed {
        logic             en;
        logic [KT_AW-1:0] addr0;
        logic [KT_AW-1:0] addr1;
    } t_key_rd;

endpackage

// ===== src/xcc_key_mem.sv =====
// Key table storage: two identical synchronous copies, one read port each,
// so both key entries of a beat are read in the same cycle. Depends on xcc_pkg.
`timescale 1ns / 1ps

module xcc_key_mem (
    input  logic             i_clk,
    input  xcc_pkg::t_key_wr i_wr,
    input  xcc_pkg::t_key_rd i_rd,
    output logic [7:0]       o_k0,
    output logic [7:0]       o_k1
);

    logic [7:0] r_mem_a [xcc_pkg::KEY_TABLE_DEPTH];
    logic [7:0] r_mem_b [xcc_pkg::KEY_TABLE_DEPTH];
    logic [7:0] r_k0;
    logic [7:0] r_k1;

    // Both copies written together during the fill
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_a[i_wr.addr] <= i_wr.data;
            r_mem_b[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered reads, held while no new beat is taken
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_k0 <= r_mem_a[i_rd.addr0];
            r_k1 <= r_mem_b[i_rd.addr1];
        end
    end

    assign o_k0 = r_k0;
    assign o_k1 = r_k1;

endmodule

// ===== src/xcc_keygen.sv =====
// Key table fill: Park-Miller generator (mod 2^31-1) and integer scaling
// of each draw by draw_range/(2^31-1). Depends on xcc_pkg.
`timescale 1ns / 1ps

module xcc_keygen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [xcc_pkg::SEED_W-1:0]  i_key_seed,
    input  logic [xcc_pkg::RANGE_W-1:0] i_draw_range,
    output xcc_pkg::t_key_wr            o_wr,
    output logic                        o_busy
);

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_RED} t_gen_state;

    t_gen_state                  r_state;
    logic [xcc_pkg::SEED_W-1:0]  r_seed;
    logic [xcc_pkg::KT_AW-1:0]   r_bidx;
    logic [45:0]                 r_gprod;
    logic                        r_draw_v;
    logic [xcc_pkg::KT_AW-1:0]   r_draw_idx;
    logic [45:0]                 r_sprod;
    logic                        r_sv;
    logic [xcc_pkg::KT_AW-1:0]   r_sidx;

    logic [31:0]                 gen_sum;
    logic [xcc_pkg::SEED_W-1:0]  n_seed;
    logic [31:0]                 scl_sum;
    logic [7:0]                  scl_byte;

    // 16807*s mod (2^31-1): fold the high part onto the low part; a fold
    // equal to the modulus stands for the fixed point s = 2^31-1
    always_comb begin
        gen_sum = {1'b0, r_gprod[30:0]} + {17'b0, r_gprod[45:31]};
        if (gen_sum > xcc_pkg::GEN_MODULUS) begin
            gen_sum = gen_sum - xcc_pkg::GEN_MODULUS;
        end
        n_seed = gen_sum[30:0];
    end

    // floor(P / (2^31-1)) = q + (q + r >= 2^31-1), q = P >> 31, r = P mod 2^31
    always_comb begin
        scl_sum  = {1'b0, r_sprod[30:0]} + {17'b0, r_sprod[45:31]};
        scl_byte = r_sprod[38:31] + 8'(scl_sum >= xcc_pkg::GEN_MODULUS);
    end

    // Sequencer, generator loop and scaling stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_draw_v <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            // scaling: multiply the fresh draw, then reduce and write
            r_sv <= r_draw_v;
            if (r_draw_v) begin
                r_sprod <= 46'(r_seed) * 46'(i_draw_range);
                r_sidx  <= r_draw_idx;
            end
            r_draw_v <= 1'b0;

            if (i_start) begin
                r_state <= ST_LOAD;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                    end
                    ST_LOAD: begin
                        r_seed  <= (i_key_seed == '0) ? xcc_pkg::SEED_W'(1) : i_key_seed;
                        r_bidx  <= xcc_pkg::KT_AW'(xcc_pkg::KEY_TABLE_DEPTH - 1);
                        r_state <= ST_MUL;
                    end
                    ST_MUL: begin
                        r_gprod <= 46'(r_seed) * 46'(xcc_pkg::GEN_MULT);
                        r_state <= ST_RED;
                    end
                    ST_RED: begin
                        r_seed     <= n_seed;
                        r_draw_v   <= 1'b1;
                        r_draw_idx <= r_bidx;
                        if (r_bidx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_bidx  <= r_bidx - 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    assign o_wr.en   = r_sv;
    assign o_wr.addr = r_sidx;
    assign o_wr.data = scl_byte;
    assign o_busy    = (r_state != ST_IDLE) || r_draw_v || r_sv;

endmodule

// ===== src/xcc_cipher.sv =====
// Byte datapath: key index walk, key reads, XOR chain and output register.
// Depends on xcc_pkg; key entries come from xcc_key_mem in the cycle after the request.
`timescale 1ns / 1ps

module xcc_cipher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fill_busy,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,
    input  logic [1:0]       i_s_tuser,
    output xcc_pkg::t_key_rd o_rd,
    input  logic [7:0]       i_k0,
    input  logic [7:0]       i_k1,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic [0:0]       o_m_tuser
);

    localparam logic [xcc_pkg::KI_W-1:0] DEPTH_KI =
        xcc_pkg::KI_W'(xcc_pkg::KEY_TABLE_DEPTH);

    logic [xcc_pkg::KI_W-1:0]  r_key_idx;
    logic [7:0]                r_chain;
    logic                      r_s1_v;
    logic                      r_s1_kind;
    logic                      r_s1_first;
    logic [7:0]                r_s1_data;
    logic                      r_s1_ovr;
    logic                      r_m_v;
    logic [7:0]                r_m_data;
    logic                      r_m_ovr;

    logic                      adv1;
    logic                      accept;
    logic [xcc_pkg::KI_W-1:0]  ki0;
    logic [xcc_pkg::KI_W-1:0]  ki1;
    logic                      wrap0;
    logic                      wrap1;
    logic [xcc_pkg::KT_AW-1:0] addr0;
    logic [xcc_pkg::KT_AW-1:0] addr1;
    logic [xcc_pkg::KI_W-1:0]  n_key_idx;
    logic [7:0]                chain_cur;
    logic [7:0]                result;

    // Handshake: stage 1 moves when the output register is free or drains
    assign adv1       = !r_m_v || i_m_tready;
    assign o_s_tready = !i_fill_busy && (!r_s1_v || adv1);
    assign accept     = i_s_tvalid && o_s_tready;

    // Two key reads per beat, each wrapping at the table end
    always_comb begin
        ki0       = i_s_tuser[1] ? '0 : r_key_idx;
        wrap0     = (ki0 >= DEPTH_KI);
        addr0     = wrap0 ? '0 : ki0[xcc_pkg::KT_AW-1:0];
        ki1       = xcc_pkg::KI_W'(addr0) + xcc_pkg::KI_W'(1);
        wrap1     = (ki1 >= DEPTH_KI);
        addr1     = wrap1 ? '0 : ki1[xcc_pkg::KT_AW-1:0];
        n_key_idx = xcc_pkg::KI_W'(addr1) + xcc_pkg::KI_W'(1);
    end

    assign o_rd.en    = accept;
    assign o_rd.addr0 = addr0;
    assign o_rd.addr1 = addr1;

    // Chain closes in stage 1
    assign chain_cur = r_s1_first ? 8'd0 : r_chain;
    assign result    = r_s1_data ^ i_k0 ^ chain_cur;

    // Stage 0 -> stage 1 (key read in flight)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_idx <= '0;
            r_s1_v    <= 1'b0;
        end else begin
            if (accept) begin
                r_key_idx  <= n_key_idx;
                r_s1_v     <= 1'b1;
                r_s1_kind  <= i_s_tuser[0];
                r_s1_first <= i_s_tuser[1];
                r_s1_data  <= i_s_tdata;
                r_s1_ovr   <= wrap0 || wrap1;
            end else if (adv1) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    // Stage 1 -> output register, chain update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= 8'd0;
            r_m_v   <= 1'b0;
        end else if (adv1) begin
            r_m_v <= r_s1_v;
            if (r_s1_v) begin
                r_m_data <= result;
                r_m_ovr  <= r_s1_ovr;
                r_chain  <= (r_s1_kind ? r_s1_data : result) ^ i_k1;
            end
        end
    end

    assign o_m_tvalid   = r_m_v;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser[0] = r_m_ovr;

endmodule

// ===== src/xor_chain_cipher_with_minstd_key_table.sv =====
// Top level of the keyed XOR chaining cipher: APB registers, key table fill,
// key table memory and byte datapath. Depends on xcc_pkg, xcc_keygen, xcc_key_mem and xcc_cipher.
//
// Usage:
//   Slave stream (i_s_*) takes one message byte per beat, last character
//   first; tuser bit 0 selects decrypt, bit 1 starts a new message (chain
//   byte and key index cleared). Master stream (o_m_*) gives one byte per
//   input beat, in order; tuser bit 0 flags a key index wrap in that beat.
//   APB port: key_seed at address 0, draw_range at address 4 (decoded on
//   paddr[2]); every write rebuilds the key table, chain and index are kept.
// Timing:
//   One beat per cycle sustained while m_tready stays high and no table
//   refill runs. A result passes the registered key table read, then the
//   XOR chain into the output register.
//   After reset and after each register write the key table is refilled
//   from the top entry down, each entry by a generator multiply, then a
//   modular fold; s_tready stays low meanwhile.
//   When the receiver stalls, one result waits in the output register and
//   one in the key read stage; s_tready then drops until m_tready returns.
`timescale 1ns / 1ps

module xor_chain_cipher_with_minstd_key_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_in
    input  logic [1:0]  i_s_tuser,  // [0] kind, [1] first_of_message
    // Master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] data_out
    output logic [0:0]  o_m_tuser   // [0] overrun
);

    // Register select (paddr[2])
    localparam logic REG_KEY_SEED   = 1'b0;
    localparam logic REG_DRAW_RANGE = 1'b1;

    logic [xcc_pkg::SEED_W-1:0]  r_key_seed;
    logic [xcc_pkg::RANGE_W-1:0] r_draw_range;
    logic                        cfg_wr;

    xcc_pkg::t_key_wr key_wr;
    xcc_pkg::t_key_rd key_rd;
    logic             fill_busy;
    logic [7:0]       k0;
    logic [7:0]       k1;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed   <= xcc_pkg::SEED_RST;
            r_draw_range <= xcc_pkg::RANGE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_KEY_SEED:   r_key_seed   <= pwdata[xcc_pkg::SEED_W-1:0];
                REG_DRAW_RANGE: r_draw_range <= pwdata[xcc_pkg::RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_KEY_SEED:   prdata = 32'(r_key_seed);
            REG_DRAW_RANGE: prdata = 32'(r_draw_range);
            default:        prdata = 32'd0;
        endcase
    end

    xcc_keygen u_keygen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (cfg_wr),
        .i_key_seed   (r_key_seed),
        .i_draw_range (r_draw_range),
        .o_wr         (key_wr),
        .o_busy       (fill_busy)
    );

    xcc_key_mem u_key_mem (
        .i_clk (i_clk),
        .i_wr  (key_wr),
        .i_rd  (key_rd),
        .o_k0  (k0),
        .o_k1  (k1)
    );

    xcc_cipher u_cipher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_busy (fill_busy),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_rd        (key_rd),
        .i_k0        (k0),
        .i_k1        (k1),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ===== test/xcc_stream_checker.sv =====
// Scoreboard for the XOR chaining cipher: watches APB and both streams,
// keeps its own copy of the key table and chain state, and compares every output beat.
// Depends on xcc_pkg for table geometry, register widths and generator constants.
`timescale 1ns / 1ps

module xcc_stream_checker
    import xcc_pkg::*;
#(
    parameter logic [2:0] ADDR_KEY_SEED   = 3'd0,
    parameter logic [2:0] ADDR_DRAW_RANGE = 3'd4,
    parameter logic       KIND_DEC        = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB, observed only
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    // Byte streams, observed only
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_in
    input  logic [1:0]  i_s_tuser,  // [0] kind, [1] first_of_message
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,  // [7:0] data_out
    input  logic [0:0]  i_m_tuser,  // [0] overrun
    // Status back to the testbench top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_wraps
);

    typedef struct packed {
        logic [7:0] data;
        logic       wrap;
    } cipher_out_t;

    // Mirrored registers and cipher state
    logic [SEED_W-1:0]  seed_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [7:0]         key_table [KEY_TABLE_DEPTH];
    logic [7:0]         chain_byte;
    logic [KI_W-1:0]    key_idx;

    cipher_out_t expected_out [$];
    int          fail_count = 0;
    int          checked    = 0;
    int          wraps      = 0;

    // One minimal-standard step: 16807 * s mod (2^31 - 1); a fixed point at 2^31 - 1
    function automatic logic [30:0] minstd_next(input logic [30:0] s);
        longint unsigned prod;
        prod = (64'(s) * 64'(GEN_MULT)) % 64'(GEN_MODULUS);
        if (prod == 0)
            prod = 64'(GEN_MODULUS);
        return prod[30:0];
    endfunction

    // Refill the whole table, top entry first, from the current registers
    function automatic void build_key_table();
        logic [30:0]     gen;
        longint unsigned scaled;
        gen = (seed_reg == '0) ? 31'd1 : seed_reg;
        for (int e = KEY_TABLE_DEPTH - 1; e >= 0; e--) begin
            gen          = minstd_next(gen);
            scaled       = (64'(gen) * 64'(range_reg)) / 64'(GEN_MODULUS);
            key_table[e] = scaled[7:0];
        end
    endfunction

    // Fetch one key entry, wrapping the index at the table end
    function automatic logic [7:0] take_key(inout logic wrapped);
        if (key_idx >= KEY_TABLE_DEPTH) begin
            key_idx = '0;
            wrapped = 1'b1;
        end
        take_key = key_table[key_idx[KT_AW-1:0]];
        key_idx  = key_idx + 1'b1;
    endfunction

    // Cipher one byte and advance the chain
    function automatic cipher_out_t cipher_byte(input logic kind, input logic first,
                                                input logic [7:0] din);
        logic        wrapped;
        logic [7:0]  k0;
        logic [7:0]  k1;
        cipher_out_t r;
        wrapped = 1'b0;
        if (first) begin
            chain_byte = '0;
            key_idx    = '0;
        end
        k0         = take_key(wrapped);
        k1         = take_key(wrapped);
        r.data     = din ^ k0 ^ chain_byte;
        r.wrap     = wrapped;
        chain_byte = ((kind == KIND_DEC) ? din : r.data) ^ k1;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    // Track registers, queue predictions on input beats, check output beats
    always @(posedge i_clk) begin
        cipher_out_t got;
        cipher_out_t want;
        logic [31:0] reg_val;
        if (!i_rst_n) begin
            seed_reg   = SEED_RST;
            range_reg  = RANGE_RST;
            chain_byte = '0;
            key_idx    = '0;
            build_key_table();
            expected_out.delete();
        end else begin
            // register access
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == ADDR_KEY_SEED) begin
                        seed_reg = i_pwdata[SEED_W-1:0];
                        build_key_table();
                    end else if (i_paddr == ADDR_DRAW_RANGE) begin
                        range_reg = i_pwdata[RANGE_W-1:0];
                        build_key_table();
                    end
                end else if (i_paddr == ADDR_KEY_SEED || i_paddr == ADDR_DRAW_RANGE) begin
                    reg_val = (i_paddr == ADDR_KEY_SEED) ? 32'(seed_reg) : 32'(range_reg);
                    if (i_prdata !== reg_val)
                        note_failure($sformatf("readback at %0d: exp %08h got %08h",
                                               i_paddr, reg_val, i_prdata));
                end
            end
            // input beat
            if (i_s_tvalid && i_s_tready)
                expected_out.push_back(cipher_byte(i_s_tuser[0], i_s_tuser[1], i_s_tdata));
            // output beat
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                got.data = i_m_tdata;
                got.wrap = i_m_tuser[0];
                if (expected_out.size() == 0) begin
                    note_failure($sformatf("unexpected beat data_out %02h overrun %0d",
                                           got.data, got.wrap));
                end else begin
                    want = expected_out.pop_front();
                    if (want.wrap)
                        wraps++;
                    if (got.data !== want.data)
                        note_failure($sformatf("data_out: exp %02h got %02h",
                                               want.data, got.data));
                    if (got.wrap !== want.wrap)
                        note_failure($sformatf("overrun: exp %0d got %0d",
                                               want.wrap, got.wrap));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_out.size();
        o_checked    <= checked;
        o_wraps      <= wraps;
    end

endmodule

// ===== test/tb_xor_chain_cipher_with_minstd_key_table.sv =====
// Testbench top for the XOR chaining cipher: clock, reset, APB and stream stimulus.
// Depends on xcc_pkg, the block and xcc_stream_checker, which does all checking.
`timescale 1ns / 1ps

module tb_xor_chain_cipher_with_minstd_key_table;

    localparam logic [2:0] ADDR_KEY_SEED   = 3'd0;
    localparam logic [2:0] ADDR_DRAW_RANGE = 3'd4;
    localparam logic       KIND_ENC        = 1'b0;
    localparam logic       KIND_DEC        = 1'b1;
    localparam int         WATCHDOG_CYCLES = 400_000;
    localparam int         HOLD_CYCLES     = 200;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;  // [0] kind, [1] first_of_message
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [0:0]  o_m_tuser;        // [0] overrun

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_off      = 1'b0;
    int   n_beats       = 0;
    int   n_settings    = 1;
    int   n_fail;
    int   n_pending;
    int   n_checked;
    int   n_wraps;

    xor_chain_cipher_with_minstd_key_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    xcc_stream_checker #(
        .ADDR_KEY_SEED   (ADDR_KEY_SEED),
        .ADDR_DRAW_RANGE (ADDR_DRAW_RANGE),
        .KIND_DEC        (KIND_DEC)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (n_fail),
        .o_pending    (n_pending),
        .o_checked    (n_checked),
        .o_wraps      (n_wraps)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 WATCHDOG_CYCLES, n_pending);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one beat, with a random gap first, and wait until it is taken
    task automatic send_beat(input logic kind, input logic first, input logic [7:0] din);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= din;
        i_s_tuser  <= {first, kind};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_beats++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read access; the checker compares prdata
    task automatic apb_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one register, read it back and let the table refill finish
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        apb_write(addr, data);
        // idle bus between the write and the read-back
        @(posedge i_clk);
        apb_read(addr);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // New key setting, only once the pipeline is empty
    task automatic set_key(input logic [31:0] seed, input logic [31:0] range);
        wait_drained();
        write_reg(ADDR_KEY_SEED, seed);
        write_reg(ADDR_DRAW_RANGE, range);
        n_settings++;
    endtask

    task automatic set_rates(input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
    endtask

    // A whole message: start flag on its first byte, kind fixed or per byte
    task automatic send_message(input logic kind, input int len, input logic mixed);
        for (int b = 0; b < len; b++)
            send_beat(mixed ? 1'($urandom_range(1)) : kind, b == 0, 8'($urandom));
    endtask

    // Mostly well-formed messages, some long enough to wrap the key index,
    // plus loose beats with random start flags and the odd full drain
    task automatic random_traffic(input int beats);
        int goal;
        int pick;
        int len;
        goal = n_beats + beats;
        while (n_beats < goal) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(250, 300)
                                               : $urandom_range(1, 40);
                send_message(1'($urandom_range(1)), len, $urandom_range(9) == 0);
            end else if (pick < 97) begin
                len = $urandom_range(1, 8);
                repeat (len)
                    send_beat(1'($urandom_range(1)), $urandom_range(3) == 0,
                              8'($urandom));
            end else begin
                wait_drained();
            end
        end
    endtask

    // Stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key: straight out of reset with no start flag, then byte extremes
        send_beat(KIND_ENC, 1'b0, 8'h00);
        send_beat(KIND_ENC, 1'b0, 8'hFF);
        send_beat(KIND_DEC, 1'b0, 8'h00);
        send_beat(KIND_DEC, 1'b0, 8'hFF);
        send_beat(KIND_ENC, 1'b1, 8'h55);
        send_beat(KIND_ENC, 1'b0, 8'hAA);
        send_beat(KIND_DEC, 1'b1, 8'hAA);
        send_beat(KIND_DEC, 1'b0, 8'h55);

        // Zero seed acts as one; zero range gives an all-zero table
        set_key(32'h0000_0000, 32'h0000_0000);
        send_beat(KIND_ENC, 1'b1, 8'h3C);
        send_beat(KIND_DEC, 1'b0, 8'hC3);
        send_beat(KIND_ENC, 1'b0, 8'hFF);
        send_beat(KIND_DEC, 1'b0, 8'h00);

        // All ones: seed masks to the generator fixed point, range to its top
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_DEC, 1'b1, 8'h00);
        send_beat(KIND_ENC, 1'b0, 8'h81);
        send_beat(KIND_DEC, 1'b0, 8'h7E);
        send_beat(KIND_ENC, 1'b1, 8'hFF);

        // Highest ordinary seed with the smallest nonzero range
        set_key(32'd2147483646, 32'd1);
        send_beat(KIND_ENC, 1'b1, 8'h01);
        send_beat(KIND_ENC, 1'b0, 8'h80);
        send_beat(KIND_DEC, 1'b1, 8'hFE);
        send_beat(KIND_DEC, 1'b0, 8'h7F);

        // Back to back, no stalls
        set_rates(0, 0);
        set_key($urandom, $urandom_range(1, 32767));
        random_traffic(280);

        // Receiver holds off while the sender keeps pushing a message that wraps
        wait_drained();
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        send_message(KIND_ENC, 300, 1'b0);

        // Sender mostly idle
        set_rates(83, 0);
        set_key($urandom, $urandom_range(1, 32767));
        random_traffic(280);

        // Receiver mostly stalled
        set_rates(0, 83);
        set_key($urandom, 32'd256);
        random_traffic(280);

        // Both sides idle now and then
        set_rates(19, 19);
        set_key($urandom, $urandom_range(1, 32767));
        random_traffic(280);

        // Drain and allow the two-stage pipeline to settle
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d beats under %0d key settings, with stalls on both sides.",
                 n_beats, n_settings);
        $display("Checked %0d results, %0d of them past the table end.",
                 n_checked, n_wraps);
        if (n_fail == 0 && n_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
src/xcc_pkg.sv
src/xcc_key_mem.sv
src/xcc_keygen.sv
src/xcc_cipher.sv
src/xor_chain_cipher_with_minstd_key_table.sv
test/xcc_stream_checker.sv
test/tb_xor_chain_cipher_with_minstd_key_table.sv
